// ----- sv/hts_pkg.sv -----
// shared types, codes and constants for the humidity and temperature sensor reader
`default_nettype none

package hts_pkg;

   // bus sequence steps, one-hot
   typedef enum logic [15:0] {
      ST_IDLE     = 16'h0001,
      ST_PRESTOP  = 16'h0002,
      ST_START    = 16'h0004,
      ST_WADDRW   = 16'h0008,
      ST_ACKADDRW = 16'h0010,
      ST_WCMD     = 16'h0020,
      ST_ACKCMD   = 16'h0040,
      ST_CONV     = 16'h0080,
      ST_RESTART  = 16'h0100,
      ST_WADDRR   = 16'h0200,
      ST_ACKADDRR = 16'h0400,
      ST_RMSB     = 16'h0800,
      ST_MACK     = 16'h1000,
      ST_RLSB     = 16'h2000,
      ST_NACK     = 16'h4000,
      ST_STOP     = 16'h8000
   } step_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_DEVICE_ADDRESS  = 3'd0,
      CSR_TEMP_COMMAND    = 3'd1,
      CSR_HUMI_COMMAND    = 3'd2,
      CSR_ACK_TIMEOUT     = 3'd3,
      CSR_CONV_WAIT_TICKS = 3'd4
   } csr_index_type;

   localparam int CsrWidth   = 16;
   localparam int ResWidth   = 12;
   localparam int RawWidth   = 16;
   localparam int ReqWidth   = 8;
   localparam int RspWidth   = 32;

   // reset values of the configuration registers
   localparam logic [6:0]  DevAddrReset  = 7'd64;
   localparam logic [7:0]  TempCmdReset  = 8'd243;
   localparam logic [7:0]  HumiCmdReset  = 8'd245;
   localparam logic [7:0]  AckTimeReset  = 8'd200;
   localparam logic [15:0] ConvWaitReset = 16'd4000;

   // code conversion constants
   localparam logic [10:0] TempScale  = 11'd1757;
   localparam logic [11:0] TempOffset = 12'd469;
   localparam logic [9:0]  HumiScale  = 10'd625;
   localparam logic [11:0] HumiOffset = 12'd60;

endpackage

`default_nettype wire

// ----- sv/hts_conv.sv -----
// raw sensor code to tenths of a degree and tenths of a percent
`default_nettype none

module hts_conv (
   input  wire logic [hts_pkg::RawWidth-1:0]        raw_code,
   output logic signed [hts_pkg::ResWidth-1:0]      temp_value,
   output logic signed [hts_pkg::ResWidth-1:0]      humi_value
);
   import hts_pkg::*;

   logic [26:0] temp_prod;
   logic [25:0] humi_prod;

   // temperature: (raw * 1757) >> 16, less 469
   assign temp_prod  = 27'(raw_code) * 27'(TempScale);
   assign temp_value = signed'({1'b0, temp_prod[26:16]} - TempOffset);

   // humidity: (raw * 625) >> 15, less 60
   assign humi_prod  = 26'(raw_code) * 26'(HumiScale);
   assign humi_value = signed'({1'b0, humi_prod[25:15]} - HumiOffset);

endmodule

`default_nettype wire

// ----- sv/humidity_temp_sensor_reader_unit.sv -----
// top level: tick-driven bus master that reads a humidity and temperature sensor
//
//  channel | dir | handshake              | content
//  req     | in  | req_tvalid/req_tready  | one bus tick: start request, sampled data line
//  rsp     | out | rsp_tvalid/rsp_tready  | line levels, status and last results per tick
//  csr     | in  | csr_we                 | register write, index and data
//
// every tick word gives exactly one result word; one word per cycle is taken while the
// output is not stalled; the sequencer registers update in the cycle a word is accepted.
// the result sits in an output register; a new word is taken while the held
// result is being taken, so a stalled output only stops input when it is full.
// reset (synchronous, high) puts the sequencer in idle, clears the results and
// loads the register defaults.
`default_nettype none

module humidity_temp_sensor_reader_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // [0] start_request, [1] sda_in, [7:2] zero
   input  wire logic [hts_pkg::ReqWidth-1:0]  req_tdata,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
   // [5] sensor_ok, [17:6] temperature, [29:18] humidity, [31:30] zero
   output logic [hts_pkg::RspWidth-1:0]       rsp_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire logic                          csr_we,
   input  wire logic [2:0]                    csr_index,
   input  wire logic [hts_pkg::CsrWidth-1:0]  csr_wdata
);
   import hts_pkg::*;

   // configuration registers
   logic [6:0]  dev_addr_ff;
   logic [7:0]  temp_cmd_ff, humi_cmd_ff, ack_time_ff;
   logic [15:0] conv_wait_ff;

   // sequencer state
   step_type    step_ff, step_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] raw_ff, raw_in;
   logic [15:0] wait_ff, wait_in;
   logic        phase_ff, phase_in;
   logic        ok_ff, ok_in;
   logic signed [ResWidth-1:0] temp_ff, temp_in, humi_ff, humi_in;

   // output register
   logic [RspWidth-1:0] rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff;

   logic accept, start_req, sda;
   logic scl, sdo, drv, done;
   logic enter_en;
   step_type enter_st;
   logic [15:0] wait_inc;
   logic [3:0]  bit_inc;
   logic signed [ResWidth-1:0] temp_conv, humi_conv;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign start_req  = req_tdata[0];
   assign sda        = req_tdata[1];
   assign wait_inc   = wait_ff + 16'd1;
   assign bit_inc    = bit_ff + 4'd1;

   hts_conv u_conv (
      .raw_code   (raw_ff),
      .temp_value (temp_conv),
      .humi_value (humi_conv)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff  <= DevAddrReset;
         temp_cmd_ff  <= TempCmdReset;
         humi_cmd_ff  <= HumiCmdReset;
         ack_time_ff  <= AckTimeReset;
         conv_wait_ff <= ConvWaitReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEVICE_ADDRESS:  dev_addr_ff  <= csr_wdata[6:0];
            CSR_TEMP_COMMAND:    temp_cmd_ff  <= csr_wdata[7:0];
            CSR_HUMI_COMMAND:    humi_cmd_ff  <= csr_wdata[7:0];
            CSR_ACK_TIMEOUT:     ack_time_ff  <= csr_wdata[7:0];
            CSR_CONV_WAIT_TICKS: conv_wait_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // one bus tick of the sequencer
   always_comb begin
      step_in  = step_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      raw_in   = raw_ff;
      wait_in  = wait_ff;
      phase_in = phase_ff;
      ok_in    = ok_ff;
      temp_in  = temp_ff;
      humi_in  = humi_ff;
      scl      = 1'b1;
      sdo      = 1'b1;
      drv      = 1'b0;
      done     = 1'b0;
      enter_en = 1'b0;
      enter_st = ST_IDLE;

      unique case (step_ff)
         ST_IDLE: begin
            if (start_req) begin
               phase_in = 1'b0;
               enter_en = 1'b1;
               enter_st = ST_PRESTOP;
            end
         end
         ST_PRESTOP, ST_STOP: begin
            scl = (bit_ff != 4'd0);
            sdo = (bit_ff == 4'd2);
            drv = 1'b1;
            if (bit_ff < 4'd2) begin
               bit_in = bit_inc;
            end else if (step_ff == ST_PRESTOP) begin
               enter_en = 1'b1;
               enter_st = ST_START;
            end else if (!phase_ff) begin
               temp_in  = temp_conv;
               phase_in = 1'b1;
               enter_en = 1'b1;
               enter_st = ST_START;
            end else begin
               humi_in  = humi_conv;
               ok_in    = 1'b1;
               phase_in = 1'b0;
               done     = 1'b1;
               enter_en = 1'b1;
               enter_st = ST_IDLE;
            end
         end
         ST_START, ST_RESTART: begin
            scl = (bit_ff == 4'd1) || (bit_ff == 4'd2);
            sdo = (bit_ff < 4'd2);
            drv = 1'b1;
            if (bit_ff < 4'd3) begin
               bit_in = bit_inc;
            end else begin
               enter_en = 1'b1;
               enter_st = (step_ff == ST_START) ? ST_WADDRW : ST_WADDRR;
            end
         end
         ST_WADDRW, ST_WCMD, ST_WADDRR: begin
            scl = (wait_ff == 16'd1);
            sdo = shift_ff[7];
            drv = 1'b1;
            if (wait_ff < 16'd2) begin
               wait_in = wait_inc;
            end else begin
               wait_in  = 16'd0;
               shift_in = {shift_ff[6:0], 1'b0};
               bit_in   = bit_inc;
               if (bit_inc >= 4'd8) begin
                  enter_en = 1'b1;
                  enter_st = (step_ff == ST_WADDRW) ? ST_ACKADDRW :
                             (step_ff == ST_WCMD)   ? ST_ACKCMD : ST_ACKADDRR;
               end
            end
         end
         ST_ACKADDRW, ST_ACKCMD, ST_ACKADDRR: begin
            scl = (bit_ff == 4'd1);
            if (bit_ff == 4'd0) begin
               bit_in  = 4'd1;
               wait_in = 16'd0;
            end else if (bit_ff == 4'd1) begin
               if (!sda) begin
                  bit_in = 4'd2;
               end else begin
                  wait_in = wait_inc;
                  if (wait_inc > {8'd0, ack_time_ff}) begin
                     if (step_ff == ST_ACKADDRW && !phase_ff) begin
                        // no sensor on the bus: abort, clear results
                        temp_in  = '0;
                        humi_in  = '0;
                        ok_in    = 1'b0;
                        done     = 1'b1;
                        enter_en = 1'b1;
                        enter_st = ST_IDLE;
                     end else if (step_ff == ST_ACKADDRW) begin
                        // humidity address lost: convert the retained code
                        humi_in  = humi_conv;
                        ok_in    = 1'b1;
                        phase_in = 1'b0;
                        done     = 1'b1;
                        enter_en = 1'b1;
                        enter_st = ST_IDLE;
                     end else begin
                        bit_in = 4'd2;
                     end
                  end
               end
            end else begin
               enter_en = 1'b1;
               enter_st = (step_ff == ST_ACKADDRW) ? ST_WCMD :
                          (step_ff == ST_ACKCMD)   ? ST_CONV : ST_RMSB;
            end
         end
         ST_CONV: begin
            scl = 1'b0;
            if (wait_ff >= conv_wait_ff) begin
               enter_en = 1'b1;
               enter_st = ST_RESTART;
            end else begin
               wait_in = wait_inc;
            end
         end
         ST_RMSB, ST_RLSB: begin
            scl = (wait_ff == 16'd1);
            if (wait_ff == 16'd0) begin
               wait_in = 16'd1;
            end else begin
               wait_in  = 16'd0;
               shift_in = {shift_ff[6:0], sda};
               bit_in   = bit_inc;
               if (bit_inc >= 4'd8) begin
                  raw_in   = (step_ff == ST_RMSB) ? {shift_in, 8'd0}
                                                  : {raw_ff[15:8], shift_in};
                  enter_en = 1'b1;
                  enter_st = (step_ff == ST_RMSB) ? ST_MACK : ST_NACK;
               end
            end
         end
         ST_MACK, ST_NACK: begin
            scl = (bit_ff == 4'd1);
            if (step_ff == ST_MACK) begin
               sdo = 1'b0;
               drv = 1'b1;
            end
            if (bit_ff < 4'd2) begin
               bit_in = bit_inc;
            end else begin
               enter_en = 1'b1;
               enter_st = (step_ff == ST_MACK) ? ST_RLSB : ST_STOP;
            end
         end
         default: begin
            enter_en = 1'b1;
            enter_st = ST_IDLE;
         end
      endcase

      // step entry clears the counters and loads the byte to send
      if (enter_en) begin
         step_in = enter_st;
         bit_in  = 4'd0;
         wait_in = 16'd0;
         case (enter_st)
            ST_WADDRW: shift_in = {dev_addr_ff, 1'b0};
            ST_WCMD:   shift_in = phase_in ? humi_cmd_ff : temp_cmd_ff;
            ST_WADDRR: shift_in = {dev_addr_ff, 1'b1};
            ST_RMSB, ST_RLSB: shift_in = 8'd0;
            default: ;
         endcase
      end

      rsp_data_in = {2'b00, humi_in, temp_in, ok_in, done,
                     (step_in != ST_IDLE), drv, sdo, scl};
   end

   // sequencer registers advance on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= ST_IDLE;
         bit_ff   <= '0;
         shift_ff <= '0;
         raw_ff   <= '0;
         wait_ff  <= '0;
         phase_ff <= 1'b0;
         ok_ff    <= 1'b0;
         temp_ff  <= '0;
         humi_ff  <= '0;
      end else if (accept) begin
         step_ff  <= step_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         raw_ff   <= raw_in;
         wait_ff  <= wait_in;
         phase_ff <= phase_in;
         ok_ff    <= ok_in;
         temp_ff  <= temp_in;
         humi_ff  <= humi_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // checks
   a_done_not_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[4] |-> !rsp_data_ff[3])
      else $error("done word still reports busy");

   a_released_high : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[2] |-> rsp_data_ff[1])
      else $error("released data line not shown high");

   a_accept_gives_word : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted tick gave no result word");

   a_idle_holds : assert property (@(posedge clock) disable iff (reset)
      step_ff == ST_IDLE && !accept |=> step_ff == ST_IDLE)
      else $error("sequencer left idle without a tick");

endmodule

`default_nettype wire
